[sv/gcng_pkg.sv]
// ----------------------------------------------------------------------------
// gcng_pkg: shared definitions of the grid cell neighbor gather unit
// Field widths, request and register codes, and the default sizes of the
// cell list tables.
// ----------------------------------------------------------------------------
package gcng_pkg;

  // Default sizes of the grid, the particle table and the neighbor cap.
  localparam int unsigned MAX_GRID_DEF      = 16;
  localparam int unsigned MAX_PARTICLES_DEF = 65536;
  localparam int unsigned MAX_NEIGHBORS_DEF = 64;

  // Field widths of the input and result words.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned VAL_W   = 17;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CNT_W   = 7;

  // Configuration register widths and port shape.
  localparam int unsigned GRID_W   = 5;
  localparam int unsigned SCALE_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 32;

  // Width of one operand of the shared multiplier.
  localparam int unsigned MUL_W = 32;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_OFFSET = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MEMBER = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NEIGHBORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [GRID_W-1:0]  GRID_SIZE_RST     = 5'd16;
  localparam logic [CNT_W-1:0]   MAX_NEIGHBORS_RST = 7'd64;
  localparam logic [SCALE_W-1:0] CELL_SCALE_RST    = 32'd65536;

endpackage

[sv/gcng_ram.sv]
// ----------------------------------------------------------------------------
// gcng_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. The read data holds until
// the next read is enabled.
// ----------------------------------------------------------------------------
module gcng_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/gcng_mul.sv]
// ----------------------------------------------------------------------------
// gcng_mul: shared multiplier of the neighbor gather unit
// One unsigned 32 by 32 product per cycle with a registered result. It
// serves both the axis cell scaling and the cell number computation.
// ----------------------------------------------------------------------------
module gcng_mul (
  input  logic                          clk_i,
  input  logic [gcng_pkg::MUL_W-1:0]    a_i,
  input  logic [gcng_pkg::MUL_W-1:0]    b_i,
  output logic [2*gcng_pkg::MUL_W-1:0]  p_o
);

  logic [2*gcng_pkg::MUL_W-1:0] p_q;

  // Product register; the sequencer picks it up in the cycle after the operands.
  always_ff @(posedge clk_i) begin
    p_q <= {{gcng_pkg::MUL_W{1'b0}}, a_i} * {{gcng_pkg::MUL_W{1'b0}}, b_i};
  end

  assign p_o = p_q;

endmodule

[sv/grid_cell_neighbor_gather_unit.sv]
// ----------------------------------------------------------------------------
// grid_cell_neighbor_gather_unit: neighbor gather over a uniform 3-D cell list
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_stall_o  | req_type, pos_x/y/z, load_*
//   out     | output    | out_valid_o / out_stall_i| neighbor_index/valid/count, last
//   cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// A query first scales the three axis cells, then visits each neighbor cell:
// one outside the grid is passed over, otherwise its cell number is computed,
// its offsets are read and its members gathered; then the result words are
// emitted (one word when nothing is found). The shared multiplier and the single
// read port of the offset table set the per-cell cost.
// The tables are not cleared by reset; rst_ni clears the sequencer state, the
// output valid flag and loads the register reset values. A stalled output
// word holds the sequencer in its emit step until the word is taken.
// ----------------------------------------------------------------------------
module grid_cell_neighbor_gather_unit #(
  parameter int unsigned MaxGrid      = gcng_pkg::MAX_GRID_DEF,
  parameter int unsigned MaxParticles = gcng_pkg::MAX_PARTICLES_DEF,
  parameter int unsigned MaxNeighbors = gcng_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [gcng_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gcng_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [gcng_pkg::REQ_W-1:0]      req_type_i,
  input  logic [gcng_pkg::POS_W-1:0]      pos_x_i,
  input  logic [gcng_pkg::POS_W-1:0]      pos_y_i,
  input  logic [gcng_pkg::POS_W-1:0]      pos_z_i,
  input  logic [gcng_pkg::ADDR_W-1:0]     load_address_i,
  input  logic [gcng_pkg::VAL_W-1:0]      load_value_i,
  // Output channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [gcng_pkg::IDX_W-1:0]      neighbor_index_o,
  output logic                            neighbor_valid_o,
  output logic [gcng_pkg::CNT_W-1:0]      neighbor_count_o,
  output logic                            last_o
);

  // Table sizes and index widths.
  localparam int unsigned OffDepth = MaxGrid * MaxGrid * MaxGrid + 1;
  localparam int unsigned OAW = $clog2(OffDepth);
  localparam int unsigned MAW = (MaxParticles > 1) ? $clog2(MaxParticles) : 1;
  localparam int unsigned FAW = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;
  // Axis cell plus one, clamped, with room for the +2 neighbor step.
  localparam int unsigned GW  = $clog2(MaxGrid + 4);
  localparam int unsigned CNW = gcng_pkg::CNT_W;
  localparam int unsigned VW  = gcng_pkg::VAL_W;
  localparam int unsigned MW  = gcng_pkg::MUL_W;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_AY   = 4'd1;
  localparam logic [3:0] ST_AZ   = 4'd2;
  localparam logic [3:0] ST_AC   = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_MG1  = 4'd5;
  localparam logic [3:0] ST_MG2  = 4'd6;
  localparam logic [3:0] ST_RS   = 4'd7;
  localparam logic [3:0] ST_RE   = 4'd8;
  localparam logic [3:0] ST_MEMB = 4'd9;
  localparam logic [3:0] ST_ERD  = 4'd10;
  localparam logic [3:0] ST_ELD  = 4'd11;

  localparam logic [1:0] STEP_LAST = 2'd2;

  // Configuration registers.
  logic [gcng_pkg::GRID_W-1:0]  grid_size_q;
  logic [CNW-1:0]               max_neighbors_q;
  logic [gcng_pkg::SCALE_W-1:0] cell_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q     <= gcng_pkg::GRID_SIZE_RST;
      max_neighbors_q <= gcng_pkg::MAX_NEIGHBORS_RST;
      cell_scale_q    <= gcng_pkg::CELL_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gcng_pkg::CFG_GRID_SIZE:     grid_size_q     <= cfg_wdata_i[gcng_pkg::GRID_W-1:0];
        gcng_pkg::CFG_MAX_NEIGHBORS: max_neighbors_q <= cfg_wdata_i[CNW-1:0];
        gcng_pkg::CFG_CELL_SCALE:    cell_scale_q    <= cfg_wdata_i[gcng_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid size and cap in use, clipped to the built sizes.
  logic [31:0]     g_full, cap_full;
  logic [GW-1:0]   g_use;
  logic [CNW-1:0]  cap_use;

  assign g_full   = (32'(grid_size_q) < 32'(MaxGrid)) ? 32'(grid_size_q) : 32'(MaxGrid);
  assign g_use    = g_full[GW-1:0];
  assign cap_full = (32'(max_neighbors_q) < 32'(MaxNeighbors)) ?
                    32'(max_neighbors_q) : 32'(MaxNeighbors);
  assign cap_use  = cap_full[CNW-1:0];

  // Sequencer registers.
  logic [3:0]           state_q, state_d;
  logic [MW-1:0]        py_q, py_d, pz_q, pz_d;
  logic [GW-1:0]        cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [1:0]           ix_q, ix_d, iy_q, iy_d, iz_q, iz_d;
  logic [OAW-1:0]       cell_q, cell_d;
  logic [VW-1:0]        slot_q, slot_d, stop_q, stop_d;
  logic [CNW-1:0]       cnt_q, cnt_d, k_q, k_d;
  logic                 wpend_q, wpend_d;
  logic [CNW-1:0]       wcnt_q, wcnt_d;

  // Shared multiplier.
  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      mul_p;

  gcng_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Cell list tables and the gathered index buffer.
  logic                 acc_in;
  logic [31:0]          load_addr32;
  logic                 off_we, off_re, mem_we, mem_re, fnd_re;
  logic [OAW-1:0]       off_raddr;
  logic [MAW-1:0]       mem_raddr;
  logic [FAW-1:0]       fnd_raddr;
  logic [VW-1:0]        off_rdata;
  logic [gcng_pkg::IDX_W-1:0] mem_rdata, fnd_rdata;
  logic [31:0]          slot32;

  assign acc_in      = in_valid_i && !in_stall_o;
  assign load_addr32 = 32'(load_address_i);
  assign off_we = acc_in && (req_type_i == gcng_pkg::REQ_OFFSET) &&
                  (load_addr32 < 32'(OffDepth));
  assign mem_we = acc_in && (req_type_i == gcng_pkg::REQ_MEMBER) &&
                  (load_addr32 < 32'(MaxParticles));
  assign slot32    = 32'(slot_q);
  assign mem_raddr = slot32[MAW-1:0];
  assign fnd_raddr = k_q[FAW-1:0];

  gcng_ram #(.Width(VW), .Depth(OffDepth)) u_offsets (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (load_addr32[OAW-1:0]),
    .wdata_i (load_value_i),
    .re_i    (off_re),
    .raddr_i (off_raddr),
    .rdata_o (off_rdata)
  );

  gcng_ram #(.Width(gcng_pkg::IDX_W), .Depth(MaxParticles)) u_members (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (load_addr32[MAW-1:0]),
    .wdata_i (load_value_i[gcng_pkg::IDX_W-1:0]),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  gcng_ram #(.Width(gcng_pkg::IDX_W), .Depth(MaxNeighbors)) u_found (
    .clk_i   (clk_i),
    .we_i    (wpend_q),
    .waddr_i (wcnt_q[FAW-1:0]),
    .wdata_i (mem_rdata),
    .re_i    (fnd_re),
    .raddr_i (fnd_raddr),
    .rdata_o (fnd_rdata)
  );

  // Neighbor coordinates, kept one above the true value so that the -1 step
  // stays unsigned: a coordinate is inside the grid when it lies in 1..g.
  logic [GW-1:0] nx1, ny1, nz1, nx, ny, nz;
  logic          nb_inside, nb_last;
  logic [1:0]    ix_adv, iy_adv, iz_adv;
  logic [31:0]   axis_hi, cell_full, stop32, stop_clip;
  logic [GW-1:0] axis_clip;

  assign nx1 = cx_q + GW'(ix_q);
  assign ny1 = cy_q + GW'(iy_q);
  assign nz1 = cz_q + GW'(iz_q);
  assign nx  = nx1 - GW'(1);
  assign ny  = ny1 - GW'(1);
  assign nz  = nz1 - GW'(1);
  assign nb_inside = (nx1 != '0) && (nx1 <= g_use) && (ny1 != '0) && (ny1 <= g_use) &&
                     (nz1 != '0) && (nz1 <= g_use);
  assign nb_last = (ix_q == STEP_LAST) && (iy_q == STEP_LAST) && (iz_q == STEP_LAST);

  // Next neighbor in x, y, z order with z running fastest.
  always_comb begin
    ix_adv = ix_q;
    iy_adv = iy_q;
    iz_adv = iz_q + 2'd1;
    if (iz_q == STEP_LAST) begin
      iz_adv = 2'd0;
      iy_adv = iy_q + 2'd1;
      if (iy_q == STEP_LAST) begin
        iy_adv = 2'd0;
        ix_adv = ix_q + 2'd1;
      end
    end
  end

  // Axis cell from the product; anything above the grid is clamped so that
  // all three of its neighbors still fall outside.
  assign axis_hi   = mul_p[2*MW-1:MW];
  assign axis_clip = (axis_hi > 32'(MaxGrid)) ? GW'(MaxGrid + 1) : axis_hi[GW-1:0];

  // Cell number and clipped end offset.
  assign cell_full = mul_p[31:0] + 32'(nz);
  assign stop32    = 32'(off_rdata);
  assign stop_clip = (stop32 > 32'(MaxParticles)) ? 32'(MaxParticles) : stop32;

  // Output register.
  logic                       out_valid_q;
  logic [gcng_pkg::IDX_W-1:0] out_idx_q;
  logic                       out_nv_q;
  logic [CNW-1:0]             out_cnt_q;
  logic                       out_last_q;
  logic                       out_free, out_load, emit_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit_last = (cnt_q == '0) || ((k_q + CNW'(1)) == cnt_q);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    py_d    = py_q;
    pz_d    = pz_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    ix_d    = ix_q;
    iy_d    = iy_q;
    iz_d    = iz_q;
    cell_d  = cell_q;
    slot_d  = slot_q;
    stop_d  = stop_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    wpend_d = 1'b0;
    wcnt_d  = wcnt_q;
    mul_a   = '0;
    mul_b   = '0;
    off_re  = 1'b0;
    off_raddr = cell_q;
    mem_re  = 1'b0;
    fnd_re  = 1'b0;
    out_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        // A query starts scaling x right away.
        if (acc_in && (req_type_i == gcng_pkg::REQ_QUERY)) begin
          mul_a   = pos_x_i;
          mul_b   = cell_scale_q;
          py_d    = pos_y_i;
          pz_d    = pos_z_i;
          state_d = ST_AY;
        end
      end
      ST_AY: begin
        cx_d    = axis_clip;
        mul_a   = py_q;
        mul_b   = cell_scale_q;
        state_d = ST_AZ;
      end
      ST_AZ: begin
        cy_d    = axis_clip;
        mul_a   = pz_q;
        mul_b   = cell_scale_q;
        state_d = ST_AC;
      end
      ST_AC: begin
        cz_d    = axis_clip;
        ix_d    = 2'd0;
        iy_d    = 2'd0;
        iz_d    = 2'd0;
        cnt_d   = '0;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        // Cells outside the grid are passed over.
        if (nb_inside) begin
          mul_a   = MW'(nx);
          mul_b   = MW'(g_use);
          state_d = ST_MG1;
        end else if (nb_last) begin
          k_d     = '0;
          state_d = ST_ERD;
        end else begin
          ix_d    = ix_adv;
          iy_d    = iy_adv;
          iz_d    = iz_adv;
        end
      end
      ST_MG1: begin
        mul_a   = mul_p[31:0] + MW'(ny);
        mul_b   = MW'(g_use);
        state_d = ST_MG2;
      end
      ST_MG2: begin
        cell_d    = cell_full[OAW-1:0];
        off_re    = 1'b1;
        off_raddr = cell_full[OAW-1:0];
        state_d   = ST_RS;
      end
      ST_RS: begin
        slot_d    = off_rdata;
        off_re    = 1'b1;
        off_raddr = cell_q + OAW'(1);
        state_d   = ST_RE;
      end
      ST_RE: begin
        stop_d  = stop_clip[VW-1:0];
        state_d = ST_MEMB;
      end
      ST_MEMB: begin
        // One member read a cycle; it is written to the buffer in the cycle after.
        if ((slot_q < stop_q) && (cnt_q < cap_use)) begin
          mem_re  = 1'b1;
          slot_d  = slot_q + VW'(1);
          cnt_d   = cnt_q + CNW'(1);
          wpend_d = 1'b1;
          wcnt_d  = cnt_q;
        end else if (nb_last) begin
          k_d     = '0;
          state_d = ST_ERD;
        end else begin
          ix_d    = ix_adv;
          iy_d    = iy_adv;
          iz_d    = iz_adv;
          state_d = ST_CHK;
        end
      end
      ST_ERD: begin
        // Wait for the last buffer write before reading it back.
        if (!wpend_q) begin
          fnd_re  = (cnt_q != '0);
          state_d = ST_ELD;
        end
      end
      ST_ELD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + CNW'(1);
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      wpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      wpend_q <= wpend_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    py_q   <= py_d;
    pz_q   <= pz_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    ix_q   <= ix_d;
    iy_q   <= iy_d;
    iz_q   <= iz_d;
    cell_q <= cell_d;
    slot_q <= slot_d;
    stop_q <= stop_d;
    wcnt_q <= wcnt_d;
  end

  // Output word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload; an empty query gives a single word marked not valid.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= (cnt_q == '0) ? '0 : fnd_rdata;
      out_nv_q   <= (cnt_q != '0);
      out_cnt_q  <= cnt_q;
      out_last_q <= emit_last;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign neighbor_index_o = out_idx_q;
  assign neighbor_valid_o = out_nv_q;
  assign neighbor_count_o = out_cnt_q;
  assign last_o           = out_last_q;

  // The gathered count never passes the cap while members are collected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEMB) |-> (cnt_q <= cap_use))
    else $error("gather count above cap");

  // Every buffer write lands inside the capped range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpend_q |-> (wcnt_q < cap_use))
    else $error("found buffer write beyond cap");

  // No buffer write is still in flight when a word is emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpend_q |-> (state_q != ST_ELD))
    else $error("emit overlaps a buffer write");

  // A word not marked valid is the lone word of an empty query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !neighbor_valid_o) |-> ((neighbor_count_o == '0) && last_o))
    else $error("empty result word malformed");

  // A free output register is filled in the emit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_ELD) && !out_valid_q) |=> out_valid_q)
    else $error("emit step did not load the output word");

endmodule
